### rtl/csrt_pkg.sv
// shared constants and types for the sparse matrix transpose block
`timescale 1ns / 1ps
`default_nettype none

package csrt_pkg;

    // field widths
    localparam int ROW_BITS   = 8;
    localparam int COL_BITS   = 8;
    localparam int NCOL_BITS  = 9;
    localparam int POS_BITS   = 10;
    localparam int VALUE_BITS = 32;

    // default sizes handed to the top level
    localparam int DEF_MAX_ENTRIES = 1024;
    localparam int DEF_MAX_DIM     = 256;

    localparam logic [NCOL_BITS-1:0] NUM_COLS_RESET = 9'd256;

    // register port
    localparam int PADDR_BITS   = 3;
    localparam int PDATA_BITS   = 32;
    localparam int REG_IDX_BITS = PADDR_BITS - 2;
    localparam logic [REG_IDX_BITS-1:0] REG_NUM_COLS = '0;

    // word kinds on the input stream
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_EMIT = 1'b1;

    // stream widths, padded to whole bytes
    localparam int S_DATA_RAW  = ROW_BITS + COL_BITS + VALUE_BITS + 1;
    localparam int S_DATA_BITS = ((S_DATA_RAW + 7) / 8) * 8;
    localparam int M_DATA_RAW  = COL_BITS + ROW_BITS + VALUE_BITS + 1 + POS_BITS;
    localparam int M_DATA_BITS = ((M_DATA_RAW + 7) / 8) * 8;
    localparam int S_USER_BITS = 1;
    localparam int M_USER_BITS = 2;

    // one stored source entry
    typedef struct packed {
        logic                  inv;
        logic [VALUE_BITS-1:0] value;
        logic [COL_BITS-1:0]   col;
        logic [ROW_BITS-1:0]   row;
    } entry_t;

    // sorter status seen by the top level
    typedef struct packed {
        logic busy;
        logic done;
    } sort_stat_t;

endpackage

`default_nettype wire

### rtl/csrt_entry_store.sv
// entry memory: one write port for loads, one registered read port
`timescale 1ns / 1ps
`default_nettype none

module csrt_entry_store #(
    parameter int MAX_ENTRIES = csrt_pkg::DEF_MAX_ENTRIES
) (
    input  wire                               clk,
    input  wire                               we,
    input  wire [$clog2(MAX_ENTRIES)-1:0]     waddr,
    input  csrt_pkg::entry_t                  wdata,
    input  wire [$clog2(MAX_ENTRIES)-1:0]     raddr,
    output csrt_pkg::entry_t                  rdata
);
    import csrt_pkg::*;

    entry_t mem [MAX_ENTRIES];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### rtl/csrt_sorter.sv
// counting sort sequencer: column counts, prefix starts and scatter into the order map
`timescale 1ns / 1ps
`default_nettype none

module csrt_sorter #(
    parameter int MAX_ENTRIES = csrt_pkg::DEF_MAX_ENTRIES,
    parameter int MAX_DIM     = csrt_pkg::DEF_MAX_DIM
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 start,
    input  wire [$clog2(MAX_ENTRIES+1)-1:0]     n_entries,
    output csrt_pkg::sort_stat_t                stat,
    output logic [$clog2(MAX_ENTRIES)-1:0]      store_addr,
    input  wire [csrt_pkg::COL_BITS-1:0]        store_col,
    input  wire [$clog2(MAX_ENTRIES)-1:0]       map_addr,
    output logic [$clog2(MAX_ENTRIES)-1:0]      map_data
);
    import csrt_pkg::*;

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int IW = $clog2(MAX_ENTRIES);
    localparam int DW = $clog2(MAX_DIM);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLR,
        S_CNT_A,
        S_CNT_B,
        S_CNT_C,
        S_PFX_A,
        S_PFX_B,
        S_SCT_A,
        S_SCT_B,
        S_SCT_C
    } sort_state_t;

    sort_state_t         state_reg;
    logic [CW-1:0]       n_reg;
    logic [CW-1:0]       i_reg;
    logic [CW-1:0]       i_next;
    logic [DW-1:0]       c_reg;
    logic [DW-1:0]       col_reg;
    logic [CW-1:0]       acc_reg;
    logic                done_reg;

    // per-column counts, later running fill positions
    logic [CW-1:0]       fill_mem [MAX_DIM];
    logic [CW-1:0]       fill_rd_reg;
    logic                fill_we;
    logic [DW-1:0]       fill_waddr;
    logic [DW-1:0]       fill_raddr;
    logic [CW-1:0]       fill_wdata;

    logic [IW-1:0]       map_mem [MAX_ENTRIES];
    logic [IW-1:0]       map_rd_reg;
    logic                map_we;

    // adder shared by counting, prefix sum and scatter
    logic [CW-1:0]       op_b;
    logic [CW-1:0]       sum;

    assign op_b   = (state_reg == S_PFX_B) ? acc_reg : CW'(1);
    assign sum    = fill_rd_reg + op_b;
    assign i_next = i_reg + CW'(1);

    assign store_addr = i_reg[IW-1:0];
    assign map_we     = (state_reg == S_SCT_C);
    assign map_data   = map_rd_reg;
    assign stat.busy  = (state_reg != S_IDLE);
    assign stat.done  = done_reg;

    always_comb
    begin
        fill_raddr = c_reg;
        fill_we    = 1'b0;
        fill_waddr = c_reg;
        fill_wdata = '0;
        unique case (state_reg)
            S_CLR:
            begin
                fill_we = 1'b1;
            end
            S_CNT_B, S_SCT_B:
            begin
                fill_raddr = DW'(store_col);
            end
            S_CNT_C, S_SCT_C:
            begin
                fill_we    = 1'b1;
                fill_waddr = col_reg;
                fill_wdata = sum;
            end
            S_PFX_B:
            begin
                fill_we    = 1'b1;
                fill_wdata = acc_reg;
            end
            default:
            begin
                fill_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (fill_we)
        begin
            fill_mem[fill_waddr] <= fill_wdata;
        end
        fill_rd_reg <= fill_mem[fill_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            map_mem[fill_rd_reg[IW-1:0]] <= i_reg[IW-1:0];
        end
        map_rd_reg <= map_mem[map_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            n_reg     <= '0;
            i_reg     <= '0;
            c_reg     <= '0;
            col_reg   <= '0;
            acc_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        n_reg     <= n_entries;
                        c_reg     <= '0;
                        state_reg <= S_CLR;
                    end
                end
                // zero every column count
                S_CLR:
                begin
                    if (c_reg == DW'(MAX_DIM - 1))
                    begin
                        i_reg     <= '0;
                        state_reg <= S_CNT_A;
                    end
                    else
                    begin
                        c_reg <= c_reg + DW'(1);
                    end
                end
                S_CNT_A:
                begin
                    state_reg <= S_CNT_B;
                end
                S_CNT_B:
                begin
                    col_reg   <= DW'(store_col);
                    state_reg <= S_CNT_C;
                end
                S_CNT_C:
                begin
                    if (i_next == n_reg)
                    begin
                        c_reg     <= '0;
                        acc_reg   <= '0;
                        state_reg <= S_PFX_A;
                    end
                    else
                    begin
                        i_reg     <= i_next;
                        state_reg <= S_CNT_A;
                    end
                end
                // exclusive prefix sum, counts become start positions
                S_PFX_A:
                begin
                    state_reg <= S_PFX_B;
                end
                S_PFX_B:
                begin
                    acc_reg <= sum;
                    if (c_reg == DW'(MAX_DIM - 1))
                    begin
                        i_reg     <= '0;
                        state_reg <= S_SCT_A;
                    end
                    else
                    begin
                        c_reg     <= c_reg + DW'(1);
                        state_reg <= S_PFX_A;
                    end
                end
                S_SCT_A:
                begin
                    state_reg <= S_SCT_B;
                end
                S_SCT_B:
                begin
                    col_reg   <= DW'(store_col);
                    state_reg <= S_SCT_C;
                end
                S_SCT_C:
                begin
                    if (i_next == n_reg)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        i_reg     <= i_next;
                        state_reg <= S_SCT_A;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### rtl/csr_sparse_transpose.sv
// top level: compressed sparse row transpose by counting sort
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake                   payload
// s_*       in         s_tvalid / s_tready         s_tdata source entry, s_tuser word kind
// m_*       out        m_tvalid / m_tready         m_tdata moved entry, m_tuser flags, m_tlast
// apb       in         psel & penable & pwrite     num_cols at byte address 0
//
// a load word leaves the block idle, so loads stream at one per cycle while the block is idle
// an emit word steps through order map read, entry read, result build, output hand-over
// the first emit after loading first runs the sorter: count clearing over every column,
//   counting over the entries, prefix sum over the columns, scattering over the entries
// reset clears the control and output registers; the memories are written before their contents are used
// a full output register holds the next result back and the block stays busy

module csr_sparse_transpose #(
    parameter int MAX_ENTRIES = csrt_pkg::DEF_MAX_ENTRIES,
    parameter int MAX_DIM     = csrt_pkg::DEF_MAX_DIM
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    // input stream
    input  wire                                   s_tvalid,
    output logic                                  s_tready,
    // src_row[7:0], src_col[15:8], entry_value[47:16], entry_invertible[48]
    input  wire [csrt_pkg::S_DATA_BITS-1:0]       s_tdata,
    // func[0]
    input  wire [csrt_pkg::S_USER_BITS-1:0]       s_tuser,
    // output stream
    output logic                                  m_tvalid,
    input  wire                                   m_tready,
    // new_row[7:0], new_col[15:8], out_value[47:16], out_invertible[48],
    // dual_position[58:49]
    output logic [csrt_pkg::M_DATA_BITS-1:0]      m_tdata,
    // entry_valid[0], overflowed[1]
    output logic [csrt_pkg::M_USER_BITS-1:0]      m_tuser,
    output logic                                  m_tlast,
    // register port
    input  wire                                   psel,
    input  wire                                   penable,
    input  wire                                   pwrite,
    input  wire [csrt_pkg::PADDR_BITS-1:0]        paddr,
    input  wire [csrt_pkg::PDATA_BITS-1:0]        pwdata,
    output logic [csrt_pkg::PDATA_BITS-1:0]       prdata,
    output logic                                  pready
);
    import csrt_pkg::*;

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int IW = $clog2(MAX_ENTRIES);

    typedef enum logic [2:0] {
        T_IDLE,
        T_SORT,
        T_MAP,
        T_STORE,
        T_FETCH,
        T_PUT
    } top_state_t;

    top_state_t                state_reg;
    logic [NCOL_BITS-1:0]      num_cols_reg;
    logic [CW-1:0]             cnt_reg;
    logic [CW-1:0]             ptr_reg;
    logic [CW-1:0]             ptr_inc;
    logic                      tposed_reg;
    logic                      ovf_reg;

    // staged result waiting for the output register
    logic [M_DATA_BITS-1:0]    res_data_reg;
    logic [M_USER_BITS-1:0]    res_user_reg;
    logic                      res_last_reg;

    logic                      m_tvalid_reg;
    logic [M_DATA_BITS-1:0]    m_tdata_reg;
    logic [M_USER_BITS-1:0]    m_tuser_reg;
    logic                      m_tlast_reg;

    // input word fields
    logic [ROW_BITS-1:0]       s_row;
    logic [COL_BITS-1:0]       s_col;
    logic [VALUE_BITS-1:0]     s_value;
    logic                      s_inv;

    logic                      col_ok;
    logic                      cnt_full;
    logic                      load_fire;
    logic                      store_we;
    entry_t                    store_wdata;
    entry_t                    store_rdata;
    logic [IW-1:0]             store_raddr;
    logic                      cfg_we;

    logic                      sort_start;
    sort_stat_t                sort_stat;
    logic [IW-1:0]             sort_addr;
    logic [IW-1:0]             map_data;

    assign s_row   = s_tdata[ROW_BITS-1:0];
    assign s_col   = s_tdata[ROW_BITS +: COL_BITS];
    assign s_value = s_tdata[ROW_BITS+COL_BITS +: VALUE_BITS];
    assign s_inv   = s_tdata[ROW_BITS+COL_BITS+VALUE_BITS];

    assign s_tready = (state_reg == T_IDLE);

    // columns outside the matrix are dropped without a flag
    assign col_ok    = ({1'b0, s_col} < num_cols_reg) && (int'(s_col) < MAX_DIM);
    assign cnt_full  = (cnt_reg == CW'(MAX_ENTRIES));
    assign load_fire = s_tvalid && s_tready && (s_tuser[0] == FUNC_LOAD);
    assign store_we  = load_fire && !tposed_reg && col_ok && !cnt_full;

    assign store_wdata.row   = s_row;
    assign store_wdata.col   = s_col;
    assign store_wdata.value = s_value;
    assign store_wdata.inv   = s_inv;

    // sorter owns the entry read port while it runs, else the order map output drives it
    assign store_raddr = sort_stat.busy ? sort_addr : map_data;

    assign sort_start = s_tvalid && s_tready && (s_tuser[0] == FUNC_EMIT)
                        && (cnt_reg != '0) && !tposed_reg;

    assign ptr_inc = ptr_reg + CW'(1);

    // register port, always ready
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite
                    && (paddr[PADDR_BITS-1:2] == REG_NUM_COLS);
    assign prdata = (paddr[PADDR_BITS-1:2] == REG_NUM_COLS) ?
                    PDATA_BITS'(num_cols_reg) : '0;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    csrt_entry_store #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (cnt_reg[IW-1:0]),
        .wdata (store_wdata),
        .raddr (store_raddr),
        .rdata (store_rdata)
    );

    csrt_sorter #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .MAX_DIM     (MAX_DIM)
    ) u_sorter (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (sort_start),
        .n_entries  (cnt_reg),
        .stat       (sort_stat),
        .store_addr (sort_addr),
        .store_col  (store_rdata.col),
        .map_addr   (ptr_reg[IW-1:0]),
        .map_data   (map_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= T_IDLE;
            num_cols_reg <= NUM_COLS_RESET;
            cnt_reg      <= '0;
            ptr_reg      <= '0;
            tposed_reg   <= 1'b0;
            ovf_reg      <= 1'b0;
            res_data_reg <= '0;
            res_user_reg <= '0;
            res_last_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            m_tuser_reg  <= '0;
            m_tlast_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                num_cols_reg <= pwdata[NCOL_BITS-1:0];
            end
            // in the hand-over state a taken word is replaced by the next one
            if (m_tvalid_reg && m_tready && (state_reg != T_PUT))
            begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                T_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        if (s_tuser[0] == FUNC_LOAD)
                        begin
                            // loads after the sort are ignored until the block clears
                            if (store_we)
                            begin
                                cnt_reg <= cnt_reg + CW'(1);
                            end
                            else if (!tposed_reg && col_ok && cnt_full)
                            begin
                                ovf_reg <= 1'b1;
                            end
                        end
                        else if (cnt_reg == '0)
                        begin
                            // empty matrix: one invalid final result, then clear
                            res_data_reg <= '0;
                            res_user_reg <= {ovf_reg, 1'b0};
                            res_last_reg <= 1'b1;
                            ovf_reg      <= 1'b0;
                            ptr_reg      <= '0;
                            tposed_reg   <= 1'b0;
                            state_reg    <= T_PUT;
                        end
                        else if (!tposed_reg)
                        begin
                            state_reg <= T_SORT;
                        end
                        else
                        begin
                            state_reg <= T_MAP;
                        end
                    end
                end
                T_SORT:
                begin
                    if (sort_stat.done)
                    begin
                        tposed_reg <= 1'b1;
                        state_reg  <= T_MAP;
                    end
                end
                // order map read at the emit pointer
                T_MAP:
                begin
                    state_reg <= T_STORE;
                end
                // entry read at the mapped source index
                T_STORE:
                begin
                    state_reg <= T_FETCH;
                end
                T_FETCH:
                begin
                    res_data_reg <= M_DATA_BITS'({POS_BITS'(ptr_reg), store_rdata.inv,
                                                  store_rdata.value, store_rdata.row,
                                                  store_rdata.col});
                    res_user_reg <= {ovf_reg, 1'b1};
                    res_last_reg <= (ptr_inc == cnt_reg);
                    if (ptr_inc == cnt_reg)
                    begin
                        // final entry clears the block
                        cnt_reg    <= '0;
                        ptr_reg    <= '0;
                        tposed_reg <= 1'b0;
                        ovf_reg    <= 1'b0;
                    end
                    else
                    begin
                        ptr_reg <= ptr_inc;
                    end
                    state_reg <= T_PUT;
                end
                T_PUT:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= res_data_reg;
                        m_tuser_reg  <= res_user_reg;
                        m_tlast_reg  <= res_last_reg;
                        state_reg    <= T_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= T_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### rtl/csrt_checker.sv
// port-level checks for the sparse transpose block, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module csrt_checker (
    input wire                                clk,
    input wire                                rst_n,
    input wire                                s_tvalid,
    input wire                                s_tready,
    input wire [csrt_pkg::S_USER_BITS-1:0]    s_tuser,
    input wire                                m_tvalid,
    input wire                                m_tready,
    input wire [csrt_pkg::M_DATA_BITS-1:0]    m_tdata,
    input wire [csrt_pkg::M_USER_BITS-1:0]    m_tuser,
    input wire                                m_tlast,
    input wire                                psel,
    input wire                                penable,
    input wire                                pwrite,
    input wire                                pready,
    input wire [csrt_pkg::PADDR_BITS-1:0]     paddr,
    input wire [csrt_pkg::PDATA_BITS-1:0]     pwdata,
    input wire [csrt_pkg::PDATA_BITS-1:0]     prdata
);
    import csrt_pkg::*;

    // stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("result word changed while stalled");

    // an empty result is final and carries zero fields
    a_empty_final: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tlast && (m_tdata == '0))
        else $error("empty result not final or not zero");

    // an emit word always keeps the block busy for the next cycle
    a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser[0] == FUNC_EMIT) |=> !s_tready)
        else $error("ready straight after an emit word");

    // num_cols reads back what was written
    a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready
         && (paddr[PADDR_BITS-1:2] == REG_NUM_COLS))
        ##1 (paddr[PADDR_BITS-1:2] == REG_NUM_COLS)
        |-> prdata == PDATA_BITS'($past(pwdata[NCOL_BITS-1:0])))
        else $error("num_cols read-back mismatch");

endmodule

bind csr_sparse_transpose csrt_checker u_csrt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .pready   (pready),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata)
);

`default_nettype wire

### verif/tb_csr_sparse_transpose.sv
// self-checking testbench for the sparse matrix transpose block
`timescale 1ns / 1ps

module tb_csr_sparse_transpose;

    import csrt_pkg::*;

    localparam int RANDOM_WORDS = 500;   // words in the random part, directed words excluded
    localparam int DRAIN_CYCLES = 16;    // settling time once every result has come back

    // one word on the input stream, fields as the block sees them
    typedef struct packed {
        logic                  func;
        logic [ROW_BITS-1:0]   row;
        logic [COL_BITS-1:0]   col;
        logic [VALUE_BITS-1:0] value;
        logic                  inv;
    } src_word_t;

    // one word on the output stream, after unpacking
    typedef struct packed {
        logic [COL_BITS-1:0]   new_row;
        logic [ROW_BITS-1:0]   new_col;
        logic [VALUE_BITS-1:0] value;
        logic                  inv;
        logic [POS_BITS-1:0]   pos;
        logic                  entry_valid;
        logic                  overflowed;
        logic                  last;
    } moved_entry_t;

    // receiver behaviour, picked again at random whenever the current mode runs out
    typedef enum int {RX_OPEN, RX_CHOPPY, RX_STALLY} rx_mode_t;

    // mirror of the transpose: holds the loaded entries, sorts them by column
    // on the first emit and queues the entry each emit is due to return
    class transpose_scoreboard;
        logic [ROW_BITS-1:0]   row_of   [DEF_MAX_ENTRIES];
        logic [COL_BITS-1:0]   col_of   [DEF_MAX_ENTRIES];
        logic [VALUE_BITS-1:0] value_of [DEF_MAX_ENTRIES];
        logic                  inv_of   [DEF_MAX_ENTRIES];
        int unsigned           column_order [DEF_MAX_ENTRIES];
        logic [NCOL_BITS-1:0]  num_cols;
        int unsigned           loaded;
        int unsigned           next_out;
        bit                    sorted;
        bit                    dropped_full;
        moved_entry_t          due_entries[$];
        int                    mismatches;

        function new();
            num_cols   = NUM_COLS_RESET;
            mismatches = 0;
            start_over();
        endfunction

        function void start_over();
            loaded       = 0;
            next_out     = 0;
            sorted       = 1'b0;
            dropped_full = 1'b0;
        endfunction

        function void set_num_cols(logic [NCOL_BITS-1:0] v);
            num_cols = v;
        endfunction

        // stable counting sort of the loaded entries by source column
        function void sort_by_column();
            int unsigned fill [DEF_MAX_DIM+1];
            int c;
            for (c = 0; c <= DEF_MAX_DIM; c++)
                fill[c] = 0;
            for (int i = 0; i < loaded; i++)
            begin
                c = col_of[i];
                fill[c+1]++;
            end
            for (c = 1; c <= DEF_MAX_DIM; c++)
                fill[c] += fill[c-1];
            for (int i = 0; i < loaded; i++)
            begin
                c = col_of[i];
                column_order[fill[c]] = i;
                fill[c]++;
            end
            next_out = 0;
            sorted   = 1'b1;
        endfunction

        function void note_word(src_word_t w);
            moved_entry_t e;
            int unsigned src;
            if (w.func == FUNC_LOAD)
            begin
                // loads while emitting, and columns out of range, are ignored
                if (sorted || w.col >= num_cols)
                    return;
                if (loaded >= DEF_MAX_ENTRIES)
                begin
                    dropped_full = 1'b1;
                    return;
                end
                row_of[loaded]   = w.row;
                col_of[loaded]   = w.col;
                value_of[loaded] = w.value;
                inv_of[loaded]   = w.inv;
                loaded++;
                return;
            end
            e = '0;
            e.overflowed = dropped_full;
            if (loaded == 0)
            begin
                // empty emit: a lone marker word, then the block starts over
                e.last = 1'b1;
                due_entries = {due_entries, e};
                start_over();
                return;
            end
            if (!sorted)
                sort_by_column();
            src           = column_order[next_out];
            e.new_row     = col_of[src];
            e.new_col     = row_of[src];
            e.value       = value_of[src];
            e.inv         = inv_of[src];
            e.pos         = next_out[POS_BITS-1:0];
            e.entry_valid = 1'b1;
            e.last        = (next_out + 1 == loaded);
            due_entries = {due_entries, e};
            if (e.last)
                start_over();
            else
                next_out++;
        endfunction

        function void report(string what, moved_entry_t want, moved_entry_t got);
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("%s: expected row %h col %h value %h inv %b pos %0d valid %b ovf %b last %b",
                         what, want.new_row, want.new_col, want.value, want.inv, want.pos,
                         want.entry_valid, want.overflowed, want.last);
                $display("%s: got      row %h col %h value %h inv %b pos %0d valid %b ovf %b last %b",
                         what, got.new_row, got.new_col, got.value, got.inv, got.pos,
                         got.entry_valid, got.overflowed, got.last);
            end
        endfunction

        function void check_entry(moved_entry_t got);
            moved_entry_t want;
            if (due_entries.size() == 0)
            begin
                report("unexpected word", '0, got);
                return;
            end
            want = due_entries.pop_front();
            if (got.new_row !== want.new_row || got.new_col !== want.new_col ||
                got.value !== want.value || got.inv !== want.inv || got.pos !== want.pos ||
                got.entry_valid !== want.entry_valid || got.overflowed !== want.overflowed ||
                got.last !== want.last)
                report("wrong word", want, got);
        endfunction
    endclass

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #10 clk = ~clk;

    // block inputs, all known from time zero
    logic                   s_tvalid = 1'b0;
    logic [S_DATA_BITS-1:0] s_tdata  = '0;
    logic [S_USER_BITS-1:0] s_tuser  = '0;
    logic                   m_tready = 1'b0;
    logic                   psel     = 1'b0;
    logic                   penable  = 1'b0;
    logic                   pwrite   = 1'b0;
    logic [PADDR_BITS-1:0]  paddr    = '0;
    logic [PDATA_BITS-1:0]  pwdata   = '0;

    // block outputs
    wire                    s_tready;
    wire                    m_tvalid;
    wire [M_DATA_BITS-1:0]  m_tdata;
    wire [M_USER_BITS-1:0]  m_tuser;
    wire                    m_tlast;
    wire [PDATA_BITS-1:0]   prdata;
    wire                    pready;

    csr_sparse_transpose uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    transpose_scoreboard sb = new();

    int words_sent = 0;
    int burst_left = 0;

    // receiver: checks every accepted word, then picks tready for the next cycle
    // values are sampled at the edge before any update of this step lands
    rx_mode_t rx_mode      = RX_OPEN;
    int       rx_mode_left = 0;
    int       rx_hold      = 0;

    always @(posedge clk)
    begin
        moved_entry_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.new_row     = m_tdata[7:0];
            got.new_col     = m_tdata[15:8];
            got.value       = m_tdata[47:16];
            got.inv         = m_tdata[48];
            got.pos         = m_tdata[58:49];
            got.entry_valid = m_tuser[0];
            got.overflowed  = m_tuser[1];
            got.last        = m_tlast;
            sb.check_entry(got);
        end
        if (rx_mode_left == 0)
        begin
            rx_mode      = rx_mode_t'($urandom_range(0, 2));
            rx_mode_left = $urandom_range(50, 400);
        end
        else
            rx_mode_left--;
        if (rx_hold > 0)
            rx_hold--;
        else
        begin
            case (rx_mode)
                RX_OPEN:
                begin
                    m_tready <= 1'b1;
                    rx_hold = 0;
                end
                RX_CHOPPY:
                begin
                    m_tready <= 1'($urandom_range(0, 1));
                    rx_hold = $urandom_range(0, 2);
                end
                default:
                begin
                    // long stalls with short open windows between them
                    if (m_tready)
                    begin
                        m_tready <= 1'b0;
                        rx_hold = $urandom_range(3, 15);
                    end
                    else
                    begin
                        m_tready <= 1'b1;
                        rx_hold = $urandom_range(0, 3);
                    end
                end
            endcase
        end
    end

    // sender: words go out in bursts, most bursts opening with a random gap
    // valid is left high after a handshake, so the next call either keeps
    // it high with new data or lowers it for a gap, never both in one step
    task automatic send_word(input src_word_t w);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= w.func;
        s_tdata  <= S_DATA_BITS'({w.inv, w.value, w.col, w.row});
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_word(w);
        words_sent++;
    endtask

    task automatic send_load(input logic [ROW_BITS-1:0] row, input logic [COL_BITS-1:0] col,
                             input logic [VALUE_BITS-1:0] value, input logic inv);
        src_word_t w;
        w.func  = FUNC_LOAD;
        w.row   = row;
        w.col   = col;
        w.value = value;
        w.inv   = inv;
        send_word(w);
    endtask

    // emit words carry junk in the unused fields
    task automatic send_emit();
        src_word_t w;
        w.func  = FUNC_EMIT;
        w.row   = ROW_BITS'($urandom);
        w.col   = COL_BITS'($urandom);
        w.value = $urandom;
        w.inv   = 1'($urandom);
        send_word(w);
    endtask

    // emits until the block has handed out its last entry and cleared itself;
    // with noise, stray loads are slipped in while the transpose is being read out
    task automatic emit_until_clear(input bit noisy);
        do
        begin
            if (noisy && sb.sorted && $urandom_range(0, 5) == 0)
                send_load(ROW_BITS'($urandom), COL_BITS'($urandom), $urandom, 1'($urandom));
            send_emit();
        end
        while (sb.loaded != 0);
    endtask

    // drop valid so nothing more is offered
    task automatic stream_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    // register writes wait for every result and a little settling time
    task automatic wait_idle();
        stream_idle();
        while (sb.due_entries.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_num_cols(input logic [NCOL_BITS-1:0] v);
        wait_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_NUM_COLS, 2'b00};
        pwdata  <= PDATA_BITS'(v);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        // register takes the value at this edge
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_num_cols(v);
    endtask

    // random matrix in row-major order, with the odd out-of-range column as noise
    task automatic load_matrix(input int n);
        int row;
        int col;
        int ncols;
        ncols = sb.num_cols;
        row   = $urandom_range(0, 255);
        col   = $urandom_range(0, ncols - 1);
        for (int i = 0; i < n; i++)
        begin
            if (ncols < 256 && $urandom_range(0, 9) == 0)
                send_load(ROW_BITS'(row), COL_BITS'($urandom_range(ncols, 255)),
                          $urandom, 1'($urandom));
            else
                send_load(ROW_BITS'(row), COL_BITS'(col), $urandom, 1'($urandom));
            if (col < ncols - 1 && $urandom_range(0, 1) == 1)
                col = $urandom_range(col + 1, ncols - 1);
            else
            begin
                if (row < 255)
                    row = $urandom_range(row + 1, (row + 3 > 255) ? 255 : row + 3);
                col = $urandom_range(0, ncols - 1);
            end
        end
    endtask

    // main sequence
    initial
    begin
        int rand_start;
        int pick;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: widest setting, extreme fields, empty emit, shared columns
        write_num_cols(9'd256);
        send_emit();
        send_load(8'd0,   8'd0,   32'h0000_0000, 1'b0);
        send_load(8'd0,   8'd255, 32'hFFFF_FFFF, 1'b1);
        send_load(8'd7,   8'd0,   32'hA5A5_A5A5, 1'b0);
        send_load(8'd7,   8'd128, 32'h5A5A_5A5A, 1'b1);
        send_load(8'd255, 8'd128, 32'h1234_5678, 1'b1);
        send_load(8'd255, 8'd255, 32'h8000_0001, 1'b0);
        send_emit();
        // load during read-out is ignored
        send_load(8'd9, 8'd3, 32'hDEAD_BEEF, 1'b1);
        emit_until_clear(1'b0);

        // narrowest setting: anything past column 0 is dropped silently
        write_num_cols(9'd1);
        send_load(8'd4, 8'd0,   32'h0F0F_0F0F, 1'b1);
        send_load(8'd5, 8'd1,   32'h1111_1111, 1'b0);
        send_load(8'd6, 8'd200, 32'h2222_2222, 1'b1);
        send_load(8'd8, 8'd0,   32'hF0F0_F0F0, 1'b0);
        emit_until_clear(1'b0);
        send_emit();
        send_load(8'd255, 8'd0, 32'hFFFF_FFFF, 1'b1);
        send_emit();

        // random part: mostly whole load and read-out runs, some empty emits
        rand_start = words_sent;
        while (words_sent - rand_start < RANDOM_WORDS)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                pick = $urandom_range(0, 3);
                if (pick == 0)
                    write_num_cols(9'd1);
                else if (pick == 1)
                    write_num_cols(9'd256);
                else if (pick == 2)
                    write_num_cols(NCOL_BITS'($urandom_range(2, 8)));
                else
                    write_num_cols(NCOL_BITS'($urandom_range(1, 256)));
            end
            if ($urandom_range(0, 9) == 0)
                send_emit();
            else
            begin
                load_matrix(($urandom_range(0, 7) == 0) ? $urandom_range(20, 80)
                                                        : $urandom_range(1, 16));
                emit_until_clear(1'b1);
            end
        end

        // drain and settle before the verdict
        stream_idle();
        while (sb.due_entries.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.due_entries.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #50_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
